>>> sv/assert_macros.svh
// Assertion macros shared by the PNG stream writer RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication checked at every clock edge outside reset.
`define PSW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define PSW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/png_sw_pkg.sv
// Constants, byte positions and CRC-32 helpers for the PNG stream writer.
// No dependencies; imported by png_stream_writer.
package png_sw_pkg;

    // Image limits and field widths.
    localparam int MAX_WIDTH   = 8192;
    localparam int MAX_HEIGHT  = 8192;
    localparam int DIM_W       = 14;
    localparam int COL_W       = 15;
    localparam int ROW_W       = 13;
    localparam int IDX_W       = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [15:0] ADLER_MOD = 16'd65521;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Fixed stream content.
    localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] TAG_IHDR      = 32'h4948_4452;
    localparam logic [31:0] TAG_IDAT      = 32'h4944_4154;
    localparam logic [31:0] TAG_IEND      = 32'h4945_4E44;
    localparam logic [31:0] IHDR_LENGTH   = 32'd13;
    localparam logic [7:0]  IHDR_DEPTH    = 8'd8;
    localparam logic [7:0]  IHDR_COLOR    = 8'd2;
    localparam logic [7:0]  ZLIB_CMF      = 8'h78;
    localparam logic [7:0]  ZLIB_FLG      = 8'h01;

    // Byte positions in the file header burst (signature, IHDR, IDAT start).
    localparam logic [IDX_W-1:0] HDR_IHDR_LEN = 6'd8;
    localparam logic [IDX_W-1:0] HDR_IHDR_TAG = 6'd12;
    localparam logic [IDX_W-1:0] HDR_WIDTH    = 6'd16;
    localparam logic [IDX_W-1:0] HDR_HEIGHT   = 6'd20;
    localparam logic [IDX_W-1:0] HDR_DEPTH    = 6'd24;
    localparam logic [IDX_W-1:0] HDR_COLOR    = 6'd25;
    localparam logic [IDX_W-1:0] HDR_IHDR_CRC = 6'd29;
    localparam logic [IDX_W-1:0] HDR_IDAT_LEN = 6'd33;
    localparam logic [IDX_W-1:0] HDR_IDAT_TAG = 6'd37;
    localparam logic [IDX_W-1:0] HDR_ZLIB_CMF = 6'd41;
    localparam logic [IDX_W-1:0] HDR_ZLIB_FLG = 6'd42;

    // Byte positions in the per-row stored-block header.
    localparam logic [IDX_W-1:0] ROW_FINAL  = 6'd0;
    localparam logic [IDX_W-1:0] ROW_LEN_LO = 6'd1;
    localparam logic [IDX_W-1:0] ROW_LEN_HI = 6'd2;
    localparam logic [IDX_W-1:0] ROW_NLN_LO = 6'd3;
    localparam logic [IDX_W-1:0] ROW_NLN_HI = 6'd4;

    // Byte positions in the closing burst (Adler, IDAT CRC, IEND).
    localparam logic [IDX_W-1:0] TAIL_IDAT_CRC = 6'd4;
    localparam logic [IDX_W-1:0] TAIL_IEND_LEN = 6'd8;
    localparam logic [IDX_W-1:0] TAIL_IEND_TAG = 6'd12;
    localparam logic [IDX_W-1:0] TAIL_IEND_CRC = 6'd16;
    localparam logic [IDX_W-1:0] TAIL_LAST     = 6'd19;

    // Reflected CRC-32 table, one entry per nibble.
    function automatic logic [31:0] crc_nibble(input logic [3:0] n);
        logic [31:0] v;
        case (n)
            4'h0:    v = 32'h0000_0000;
            4'h1:    v = 32'h1db7_1064;
            4'h2:    v = 32'h3b6e_20c8;
            4'h3:    v = 32'h26d9_30ac;
            4'h4:    v = 32'h76dc_4190;
            4'h5:    v = 32'h6b6b_51f4;
            4'h6:    v = 32'h4db2_6158;
            4'h7:    v = 32'h5005_713c;
            4'h8:    v = 32'hedb8_8320;
            4'h9:    v = 32'hf00f_9344;
            4'ha:    v = 32'hd6d6_a3e8;
            4'hb:    v = 32'hcb61_b38c;
            4'hc:    v = 32'h9b64_c2b0;
            4'hd:    v = 32'h86d3_d2d4;
            4'he:    v = 32'ha00a_e278;
            default: v = 32'hbdbd_f21c;
        endcase
        return v;
    endfunction

    // Folds one byte into the running CRC, two nibbles per byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        x = (x >> 4) ^ crc_nibble(x[3:0]);
        x = (x >> 4) ^ crc_nibble(x[3:0]);
        return x;
    endfunction

    // Picks byte k of a word, most significant first.
    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = w[31:24];
            2'd1:    v = w[23:16];
            2'd2:    v = w[15:8];
            default: v = w[7:0];
        endcase
        return v;
    endfunction

endpackage

>>> sv/png_stream_writer.sv
// PNG stream writer: RGB bytes in, PNG file bytes out (stored deflate blocks).
// Depends on png_sw_pkg and assert_macros.svh.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, pixel_byte            | in
//  output   | out_valid, out_ready, out_byte,           | out
//           | last_of_run, file_done                    |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One output beat leaves per cycle while a byte is held and out_ready is high;
// an input beat yields 1 byte for a plain pixel byte, 7 at a row start, 50 for
// the first byte of a file and 20 more for the last one. The byte sequencer sets this.
// Reset is asynchronous; the block then waits for the first byte of a file.
// A stalled output holds the sequencer, and with it the input register.
`include "assert_macros.svh"

module png_stream_writer
    import png_sw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             pixel_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   last_of_run,
    output logic                   file_done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        P_HDR,
        P_ROW,
        P_PIX,
        P_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        CRC_HOLD,
        CRC_FEED,
        CRC_INIT
    } crc_op_t;

    // Registers.
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [DIM_W-1:0] image_width_reg, image_width_next;
    logic [DIM_W-1:0] image_height_reg, image_height_next;
    logic [DIM_W-1:0] cur_w_reg, cur_w_next;
    logic [DIM_W-1:0] cur_h_reg, cur_h_next;
    logic [31:0]      idat_len_reg, idat_len_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      adler_low_reg, adler_low_next;
    logic [15:0]      adler_high_reg, adler_high_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             item_valid_reg, item_valid_next;
    logic [7:0]       pixel_reg, pixel_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;
    logic             done_reg, done_next;

    // Sequencer signals.
    logic             advance;
    logic [7:0]       gen_byte;
    crc_op_t          gen_crc;
    logic             gen_adler;
    logic             gen_last;
    logic             gen_done;
    phase_t           gen_phase;
    logic [IDX_W-1:0] gen_idx;
    logic [COL_W-1:0] width3;
    logic [COL_W-1:0] rowlen;
    logic [COL_W-1:0] col_plus;
    logic             row_is_last;
    logic [DIM_W-1:0] sat_w;
    logic [DIM_W-1:0] sat_h;
    logic [16:0]      lo_sum;
    logic [16:0]      hi_sum;
    logic [15:0]      lo_new;
    logic [15:0]      hi_new;

    // Derived row geometry of the current file.
    assign width3      = ({1'b0, cur_w_reg} << 1) + {1'b0, cur_w_reg};
    assign rowlen      = width3 + 15'd1;
    assign col_plus    = column_reg + 15'd1;
    assign row_is_last = (({1'b0, row_reg} + 14'd1) == cur_h_reg);

    // Saturated image size, latched at the first byte of a file.
    assign sat_w = (image_width_reg == '0) ? 14'd1 :
                   ({1'b0, image_width_reg} > 15'(MAX_WIDTH)) ? 14'(MAX_WIDTH) :
                   image_width_reg;
    assign sat_h = (image_height_reg == '0) ? 14'd1 :
                   ({1'b0, image_height_reg} > 15'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) :
                   image_height_reg;

    // Handshakes.
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || (advance && gen_last);
    assign cfg_ready = 1'b1;

    // Byte sequencer: picks the next stream byte and where the sequence goes.
    always_comb
    begin
        gen_byte  = 8'd0;
        gen_crc   = CRC_HOLD;
        gen_adler = 1'b0;
        gen_last  = 1'b0;
        gen_done  = 1'b0;
        gen_phase = phase_reg;
        gen_idx   = idx_reg + 6'd1;
        case (phase_reg)
            P_HDR:
            begin
                if (idx_reg < HDR_IHDR_LEN)
                begin
                    gen_byte = PNG_SIGNATURE[8*(7-idx_reg[2:0]) +: 8];
                end
                else if (idx_reg < HDR_IHDR_TAG)
                begin
                    gen_byte = be_byte(IHDR_LENGTH, idx_reg[1:0]);
                    gen_crc  = CRC_INIT;
                end
                else if (idx_reg < HDR_WIDTH)
                begin
                    gen_byte = be_byte(TAG_IHDR, idx_reg[1:0]);
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg < HDR_HEIGHT)
                begin
                    gen_byte = be_byte({18'd0, cur_w_reg}, idx_reg[1:0]);
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg < HDR_DEPTH)
                begin
                    gen_byte = be_byte({18'd0, cur_h_reg}, idx_reg[1:0]);
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg == HDR_DEPTH)
                begin
                    gen_byte = IHDR_DEPTH;
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg == HDR_COLOR)
                begin
                    gen_byte = IHDR_COLOR;
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg < HDR_IHDR_CRC)
                begin
                    gen_crc = CRC_FEED;
                end
                else if (idx_reg < HDR_IDAT_LEN)
                begin
                    gen_byte = be_byte(~crc_reg, 2'(idx_reg - HDR_IHDR_CRC));
                end
                else if (idx_reg < HDR_IDAT_TAG)
                begin
                    gen_byte = be_byte(idat_len_reg, 2'(idx_reg - HDR_IDAT_LEN));
                    gen_crc  = CRC_INIT;
                end
                else if (idx_reg < HDR_ZLIB_CMF)
                begin
                    gen_byte = be_byte(TAG_IDAT, 2'(idx_reg - HDR_IDAT_TAG));
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg == HDR_ZLIB_CMF)
                begin
                    gen_byte = ZLIB_CMF;
                    gen_crc  = CRC_FEED;
                end
                else
                begin
                    gen_byte  = ZLIB_FLG;
                    gen_crc   = CRC_FEED;
                    gen_phase = P_ROW;
                    gen_idx   = '0;
                end
            end
            P_ROW:
            begin
                gen_crc = CRC_FEED;
                case (idx_reg)
                    ROW_FINAL:  gen_byte = {7'd0, row_is_last};
                    ROW_LEN_LO: gen_byte = rowlen[7:0];
                    ROW_LEN_HI: gen_byte = {1'b0, rowlen[14:8]};
                    ROW_NLN_LO: gen_byte = ~rowlen[7:0];
                    ROW_NLN_HI: gen_byte = {1'b1, ~rowlen[14:8]};
                    default:
                    begin
                        // Filter type byte, counted in Adler-32.
                        gen_byte  = 8'd0;
                        gen_adler = 1'b1;
                        gen_phase = P_PIX;
                        gen_idx   = '0;
                    end
                endcase
            end
            P_PIX:
            begin
                gen_byte  = pixel_reg;
                gen_crc   = CRC_FEED;
                gen_adler = 1'b1;
                gen_idx   = '0;
                if (col_plus == width3 && row_is_last)
                begin
                    gen_phase = P_TAIL;
                end
                else if (col_plus == width3)
                begin
                    gen_phase = P_ROW;
                    gen_last  = 1'b1;
                end
                else
                begin
                    gen_last = 1'b1;
                end
            end
            default:
            begin
                if (idx_reg < TAIL_IDAT_CRC)
                begin
                    gen_byte = be_byte({adler_high_reg, adler_low_reg}, idx_reg[1:0]);
                    gen_crc  = CRC_FEED;
                end
                else if (idx_reg < TAIL_IEND_LEN)
                begin
                    gen_byte = be_byte(~crc_reg, idx_reg[1:0]);
                end
                else if (idx_reg < TAIL_IEND_TAG)
                begin
                    gen_crc = CRC_INIT;
                end
                else if (idx_reg < TAIL_IEND_CRC)
                begin
                    gen_byte = be_byte(TAG_IEND, idx_reg[1:0]);
                    gen_crc  = CRC_FEED;
                end
                else
                begin
                    gen_byte = be_byte(~crc_reg, idx_reg[1:0]);
                    if (idx_reg == TAIL_LAST)
                    begin
                        gen_last  = 1'b1;
                        gen_done  = 1'b1;
                        gen_phase = P_HDR;
                        gen_idx   = '0;
                    end
                end
            end
        endcase
    end

    // Adler-32 step with one conditional subtract per sum.
    always_comb
    begin
        lo_sum = {1'b0, adler_low_reg} + {9'd0, gen_byte};
        lo_new = (lo_sum >= {1'b0, ADLER_MOD}) ? 16'(lo_sum - {1'b0, ADLER_MOD})
                                               : lo_sum[15:0];
        hi_sum = {1'b0, adler_high_reg} + {1'b0, lo_new};
        hi_new = (hi_sum >= {1'b0, ADLER_MOD}) ? 16'(hi_sum - {1'b0, ADLER_MOD})
                                               : hi_sum[15:0];
    end

    // Next state of the whole block.
    always_comb
    begin
        phase_next        = phase_reg;
        idx_next          = idx_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        cur_w_next        = cur_w_reg;
        cur_h_next        = cur_h_reg;
        crc_next          = crc_reg;
        adler_low_next    = adler_low_reg;
        adler_high_next   = adler_high_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        item_valid_next   = item_valid_reg;
        pixel_next        = pixel_reg;
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        last_next         = last_reg;
        done_next         = done_reg;

        // IDAT length follows the latched size; it is read long after the latch.
        idat_len_next = 32'd6 + 32'(cur_h_reg) * (32'(width3) + 32'd6);

        // Configuration writes; indexes beyond the list are dropped.
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                image_width_next = cfg_data;
            end
            else if (cfg_index == REG_IMAGE_HEIGHT)
            begin
                image_height_next = cfg_data;
            end
        end

        // Sequencer step and result register load.
        if (advance)
        begin
            phase_next     = gen_phase;
            idx_next       = gen_idx;
            out_valid_next = 1'b1;
            out_byte_next  = gen_byte;
            last_next      = gen_last;
            done_next      = gen_done;
            if (phase_reg == P_HDR && idx_reg == '0)
            begin
                cur_w_next = sat_w;
                cur_h_next = sat_h;
            end
            case (gen_crc)
                CRC_FEED: crc_next = crc_byte(crc_reg, gen_byte);
                CRC_INIT: crc_next = '1;
                default:  crc_next = crc_reg;
            endcase
            if (gen_adler)
            begin
                adler_low_next  = lo_new;
                adler_high_next = hi_new;
            end
            if (phase_reg == P_PIX)
            begin
                if (col_plus == width3)
                begin
                    column_next = '0;
                    row_next    = row_reg + 13'd1;
                end
                else
                begin
                    column_next = col_plus;
                end
            end
            if (gen_done)
            begin
                crc_next        = '1;
                adler_low_next  = 16'd1;
                adler_high_next = 16'd0;
                column_next     = '0;
                row_next        = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Input register.
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
            pixel_next      = pixel_byte;
        end
        else if (advance && gen_last)
        begin
            item_valid_next = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= P_HDR;
            idx_reg          <= '0;
            image_width_reg  <= 14'd1;
            image_height_reg <= 14'd1;
            cur_w_reg        <= 14'd1;
            cur_h_reg        <= 14'd1;
            idat_len_reg     <= '0;
            crc_reg          <= '1;
            adler_low_reg    <= 16'd1;
            adler_high_reg   <= 16'd0;
            column_reg       <= '0;
            row_reg          <= '0;
            item_valid_reg   <= 1'b0;
            pixel_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= '0;
            last_reg         <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            idx_reg          <= idx_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            cur_w_reg        <= cur_w_next;
            cur_h_reg        <= cur_h_next;
            idat_len_reg     <= idat_len_next;
            crc_reg          <= crc_next;
            adler_low_reg    <= adler_low_next;
            adler_high_reg   <= adler_high_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            item_valid_reg   <= item_valid_next;
            pixel_reg        <= pixel_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            last_reg         <= last_next;
            done_reg         <= done_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign file_done   = done_reg;

    // The last IEND beat always closes the run of its input beat.
    `PSW_ASSERT_IMP(a_done_is_last, out_valid_reg && done_reg, last_reg, "file_done without last_of_run")
    // Finishing a file returns the sequencer and checksums to their start values.
    `PSW_ASSERT_NXT(a_done_restarts, advance && gen_done, phase_reg == P_HDR && idx_reg == '0 && crc_reg == '1 && adler_low_reg == 16'd1 && adler_high_reg == 16'd0, "file end did not restart")
    // Both Adler sums stay reduced below the modulus.
    `PSW_ASSERT(a_adler_reduced, adler_low_reg < ADLER_MOD && adler_high_reg < ADLER_MOD, "Adler sum out of range")
    // The column counter never reaches the row length.
    `PSW_ASSERT(a_column_range, column_reg < width3, "column counter past row end")

endmodule
